FILE: rtl/tvcc_pkg.sv
// Shared types, constants and state codes for the trajectory velocity cost block.
`default_nettype none
package tvcc_pkg;
   localparam int SumWidth  = 48;
   localparam int CostWidth = 32;
   localparam int CsrAddrWidth = 5;
   localparam logic [SumWidth-1:0] SumMax = {SumWidth{1'b1}};

   localparam logic [2:0] RegEnable   = 3'd0;
   localparam logic [2:0] RegMode     = 3'd1;
   localparam logic [2:0] RegUpper    = 3'd2;
   localparam logic [2:0] RegLower    = 3'd3;
   localparam logic [2:0] RegGain     = 3'd4;
   localparam logic [2:0] RegExponent = 3'd5;
   localparam logic [2:0] RegRadius   = 3'd6;
   localparam logic [2:0] RegStep     = 3'd7;

   localparam logic [1:0] ModeOmni = 2'd1;
   localparam logic [1:0] ModeAck  = 2'd2;

   typedef struct packed {
      logic signed [15:0] lin_x;
      logic signed [15:0] lin_y;
      logic signed [15:0] yaw_rate;
      logic               row_end;
   } req_type;

   typedef struct packed {
      logic [31:0] traj_cost;
      logic        saturated;
   } rsp_type;

   typedef struct packed {
      logic        enable;
      logic [1:0]  motion_mode;
      logic signed [15:0] speed_upper;
      logic signed [15:0] speed_lower;
      logic [15:0] cost_gain;
      logic [3:0]  cost_exponent;
      logic [14:0] turn_radius_min;
      logic [15:0] time_step;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROOT, ST_DIV, ST_VIOL, ST_ACC, ST_GAIN_LO, ST_GAIN_HI,
      ST_POW_LO, ST_POW_HI, ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture sample
      logic root_step;  // one sqrt iteration
      logic div_step;   // one divider iteration
      logic viol;       // compute violation
      logic acc;        // accumulate
      logic gain_lo;    // low half of sum*gain
      logic gain_hi;    // high half, base
      logic pow_lo;     // low half of r*base
      logic pow_hi;     // finish r*base
      logic clear_sum;  // clear accumulator
      logic out_load;   // load output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic iter_done;
      logic pow_done;
   } sts_type;
endpackage
`default_nettype wire

FILE: rtl/tvcc_ctrl.sv
// Sequencer for one sample: iterate sqrt/divide where the mode needs it, accumulate, and finish the cost on a row end.
`default_nettype none
module tvcc_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic req_row_end,
   input  wire logic cfg_enable,
   input  wire logic [1:0] cfg_mode,
   input  wire logic rsp_busy,
   input  wire tvcc_pkg::sts_type sts,
   output tvcc_pkg::cmd_type cmd
);
   import tvcc_pkg::*;
   state_type state_ff, state_in;
   logic last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_row_end;
               if (!cfg_enable) begin
                  cmd.clear_sum = req_row_end;
               end else if (cfg_mode == ModeOmni) begin
                  state_in = ST_ROOT;
               end else if (cfg_mode == ModeAck) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_VIOL;
               end
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.iter_done) state_in = ST_VIOL;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.iter_done) state_in = ST_VIOL;
         end
         ST_VIOL: begin
            cmd.viol = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = last_ff ? ST_GAIN_LO : ST_IDLE;
         end
         ST_GAIN_LO: begin
            cmd.gain_lo = 1'b1;
            state_in = ST_GAIN_HI;
         end
         ST_GAIN_HI: begin
            cmd.gain_hi = 1'b1;
            state_in = sts.pow_done ? ST_OUT : ST_POW_LO;
         end
         ST_POW_LO: begin
            cmd.pow_lo = 1'b1;
            state_in = ST_POW_HI;
         end
         ST_POW_HI: begin
            cmd.pow_hi = 1'b1;
            state_in = sts.pow_done ? ST_OUT : ST_POW_LO;
         end
         ST_OUT: begin
            if (!rsp_busy) begin
               cmd.out_load  = 1'b1;
               cmd.clear_sum = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/tvcc_dp.sv
// Datapath: shared sqrt/divide iterator, violation, accumulator and power unit.
`default_nettype none
module tvcc_dp (
   input  wire logic clock,
   input  wire logic reset,
   input  wire tvcc_pkg::req_type req,
   input  wire tvcc_pkg::cfg_type cfg,
   input  wire tvcc_pkg::cmd_type cmd,
   output tvcc_pkg::sts_type sts,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output tvcc_pkg::rsp_type rsp
);
   import tvcc_pkg::*;

   logic signed [16:0] vx_ff;
   logic [15:0] aw_ff;
   logic [31:0] rem_ff, quo_ff;   // sqrt: x, r ; div: remainder, quotient
   logic [31:0] num_ff;           // sqrt bit / dividend shift register
   logic [4:0]  cnt_ff;
   logic        wz_zero_ff;
   logic [17:0] viol_ff;
   logic [SumWidth-1:0] sum_ff;
   logic [32:0] base_ff, r_ff;
   logic [47:0] plo_ff;
   logic [3:0]  pcnt_ff;
   logic        sat_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic signed [31:0] sqx, sqy;
   logic [31:0] sq;
   logic [15:0] ax, aw;
   assign sqx = 32'(signed'(req.lin_x)) * 32'(signed'(req.lin_x));
   assign sqy = 32'(signed'(req.lin_y)) * 32'(signed'(req.lin_y));
   assign sq  = 32'(sqx) + 32'(sqy);
   assign ax  = req.lin_x[15] ? 16'(-req.lin_x) : req.lin_x;
   assign aw  = req.yaw_rate[15] ? 16'(-req.yaw_rate) : req.yaw_rate;

   // sqrt iteration
   logic [32:0] rpb;
   assign rpb = 33'(quo_ff) + 33'(num_ff);
   // divide iteration: restoring, 28-bit dividend (ax<<12)
   logic [16:0] dtrial;
   logic [16:0] dshift;
   assign dshift = {rem_ff[15:0], num_ff[27]};
   assign dtrial = dshift - 17'(aw_ff);

   // violation
   logic signed [18:0] vel, over, under;
   logic [16:0] extra;
   always_comb begin
      vel = 19'(vx_ff);
      if (cfg.motion_mode == ModeOmni) begin
         vel = (vx_ff > 0) ? 19'(quo_ff) : -19'(quo_ff);
      end
      over  = vel - 19'(cfg.speed_upper);
      under = 19'(cfg.speed_lower) - vel;
      extra = '0;
      if (cfg.motion_mode == ModeAck && !wz_zero_ff &&
          {17'd0, cfg.turn_radius_min} > quo_ff)
         extra = 17'(32'(cfg.turn_radius_min) - quo_ff);
   end

   logic [33:0] add;
   logic [SumWidth:0] sum_next;
   assign add = 34'(viol_ff) * 34'(cfg.time_step);
   assign sum_next = {1'b0, sum_ff} + (SumWidth+1)'(add);

   // sum*gain in two halves: 24x16 each
   logic [39:0] glo, ghi;
   assign glo = 40'(sum_ff[23:0]) * 40'(cfg.cost_gain);
   assign ghi = 40'(sum_ff[47:24]) * 40'(cfg.cost_gain);
   // r*base in two halves: 16x33 and 17x33 style split of r
   logic [48:0] plo, phi;
   assign plo = 49'(r_ff[15:0]) * 49'(base_ff);
   assign phi = 49'(r_ff[32:16]) * 49'(base_ff);
   logic [65:0] gfull, pfull;
   assign gfull = (66'(ghi) << 24) + 66'(plo_ff);
   assign pfull = (66'(phi) << 16) + 66'(plo_ff);
   logic [3:0] expo;
   assign expo = (cfg.cost_exponent == 4'd0) ? 4'd1 : cfg.cost_exponent;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vx_ff <= 17'(req.lin_x);
         aw_ff <= aw;
         wz_zero_ff <= (aw == 16'd0);
         quo_ff <= '0;
         cnt_ff <= '0;
         if (cfg.motion_mode == ModeOmni) begin
            rem_ff <= sq;
            num_ff <= 32'h4000_0000;
         end else begin
            rem_ff <= '0;
            num_ff <= {4'd0, ax, 12'd0};
         end
      end
      if (cmd.root_step) begin
         cnt_ff <= cnt_ff + 5'd1;
         num_ff <= num_ff >> 2;
         if ({1'b0, rem_ff} >= rpb) begin
            rem_ff <= rem_ff - rpb[31:0];
            quo_ff <= (quo_ff >> 1) + num_ff;
         end else begin
            quo_ff <= quo_ff >> 1;
         end
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 5'd1;
         num_ff <= num_ff << 1;
         if (!wz_zero_ff && !dtrial[16]) begin
            rem_ff <= 32'(dtrial);
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= 32'(dshift);
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.viol) begin
         viol_ff <= 18'(extra) + (over > 0 ? 18'(over) : 18'd0)
                  + (under > 0 ? 18'(under) : 18'd0);
      end
      if (cmd.gain_lo) plo_ff <= 48'(glo);
      if (cmd.gain_hi) begin
         pcnt_ff <= 4'd1;
         if (gfull[65:52] != '0) begin
            base_ff <= 33'h0_FFFF_FFFF;
            r_ff    <= 33'h0_FFFF_FFFF;
            sat_ff  <= 1'b1;
         end else begin
            base_ff <= 33'(gfull[51:20]);
            r_ff    <= 33'(gfull[51:20]);
            sat_ff  <= 1'b0;
         end
      end
      if (cmd.pow_lo) plo_ff <= 48'(plo);
      if (cmd.pow_hi) begin
         pcnt_ff <= pcnt_ff + 4'd1;
         if (pfull[65:48] != '0) begin
            r_ff   <= 33'h0_FFFF_FFFF;
            sat_ff <= 1'b1;
         end else begin
            r_ff <= 33'(pfull[47:16]);
         end
      end
      if (cmd.out_load) begin
         rsp_ff.traj_cost <= r_ff[31:0];
         rsp_ff.saturated <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_sum) sum_ff <= '0;
         else if (cmd.acc) sum_ff <= sum_next[SumWidth] ? SumMax : sum_next[SumWidth-1:0];
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // sqrt runs 16 steps, divide 28
   assign sts.iter_done = cmd.root_step ? (cnt_ff == 5'd15) : (cnt_ff == 5'd27);
   assign sts.pow_done  = cmd.gain_hi ? (expo == 4'd1) : (pcnt_ff + 4'd1 == expo);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule
`default_nettype wire

FILE: rtl/trajectory_velocity_constraint_cost.sv
// Top level of the trajectory velocity-constraint cost block.
// Omni samples run 16 sqrt iterations and ackermann samples 28 divide iterations
//   of one shared iterator; a last sample adds the gain and power steps.
// A new sample is taken only once the last one is finished; the output register
//   lets the next sample enter while a cost waits to be taken.
// Reset: synchronous, clears the accumulator, sequencer and output valid;
//   configuration registers return to their reset defaults.
`default_nettype none
module trajectory_velocity_constraint_cost (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire tvcc_pkg::req_type req_data,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output tvcc_pkg::rsp_type rsp_data,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [tvcc_pkg::CsrAddrWidth-1:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic      pready
);
   import tvcc_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   logic [2:0] reg_idx;
   assign reg_idx = paddr[4:2];
   assign pready  = 1'b1;

   // Register file: write on the access phase of a transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable          <= 1'b1;
         cfg_ff.motion_mode     <= 2'd0;
         cfg_ff.speed_upper     <= 16'sd2048;
         cfg_ff.speed_lower     <= -16'sd1434;
         cfg_ff.cost_gain       <= 16'd1024;
         cfg_ff.cost_exponent   <= 4'd1;
         cfg_ff.turn_radius_min <= 15'd0;
         cfg_ff.time_step       <= 16'd3277;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            RegEnable:   cfg_ff.enable          <= pwdata[0];
            RegMode:     cfg_ff.motion_mode     <= pwdata[1:0];
            RegUpper:    cfg_ff.speed_upper     <= pwdata[15:0];
            RegLower:    cfg_ff.speed_lower     <= pwdata[15:0];
            RegGain:     cfg_ff.cost_gain       <= pwdata[15:0];
            RegExponent: cfg_ff.cost_exponent   <= pwdata[3:0];
            RegRadius:   cfg_ff.turn_radius_min <= pwdata[14:0];
            RegStep:     cfg_ff.time_step       <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register.
   always_comb begin
      case (reg_idx)
         RegEnable:   prdata = 32'(cfg_ff.enable);
         RegMode:     prdata = 32'(cfg_ff.motion_mode);
         RegUpper:    prdata = 32'(signed'(cfg_ff.speed_upper));
         RegLower:    prdata = 32'(signed'(cfg_ff.speed_lower));
         RegGain:     prdata = 32'(cfg_ff.cost_gain);
         RegExponent: prdata = 32'(cfg_ff.cost_exponent);
         RegRadius:   prdata = 32'(cfg_ff.turn_radius_min);
         RegStep:     prdata = 32'(cfg_ff.time_step);
         default:     prdata = '0;
      endcase
   end

   // Sequencer: hold a finished cost until the output register frees up.
   tvcc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .req_row_end(req_data.row_end),
      .cfg_enable(cfg_ff.enable),
      .cfg_mode(cfg_ff.motion_mode),
      .rsp_busy(rsp_valid && !rsp_ready),
      .sts, .cmd
   );

   tvcc_dp u_dp (
      .clock, .reset, .req(req_data), .cfg(cfg_ff), .cmd, .sts,
      .rsp_valid, .rsp_ready, .rsp(rsp_data)
   );
endmodule
`default_nettype wire

FILE: rtl/tvcc_checker.sv
// Port-level checker for the trajectory velocity cost block, bound to the top.
`default_nettype none
module tvcc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire tvcc_pkg::rsp_type rsp_data,
   input wire logic pready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.traj_cost == 32'hFFFF_FFFF)
      else $error("saturated without full-scale cost");
   a_ready_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(req_ready))
      else $error("input ready unknown");
   a_pready: assert property (@(posedge clock) pready)
      else $error("pready dropped");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind trajectory_velocity_constraint_cost tvcc_checker u_tvcc_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_data, .pready
);
`default_nettype wire

FILE: test/tb_trajectory_velocity_constraint_cost.sv
// Self-checking testbench for the trajectory velocity-constraint cost block.
`default_nettype none

// Scoreboard: predicts the cost of each finished trajectory and checks results.
class cost_scoreboard;
   tvcc_pkg::cfg_type cfg;
   logic [47:0] viol_sum;
   tvcc_pkg::rsp_type pending[$];
   int errors;
   int checked;

   function new();
      cfg.enable          = 1'b1;
      cfg.motion_mode     = 2'd0;
      cfg.speed_upper     = 16'sd2048;
      cfg.speed_lower     = -16'sd1434;
      cfg.cost_gain       = 16'd1024;
      cfg.cost_exponent   = 4'd1;
      cfg.turn_radius_min = 15'd0;
      cfg.time_step       = 16'd3277;
      viol_sum = '0;
      errors = 0;
      checked = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         tvcc_pkg::RegEnable:   cfg.enable = val[0];
         tvcc_pkg::RegMode:     cfg.motion_mode = val[1:0];
         tvcc_pkg::RegUpper:    cfg.speed_upper = val[15:0];
         tvcc_pkg::RegLower:    cfg.speed_lower = val[15:0];
         tvcc_pkg::RegGain:     cfg.cost_gain = val[15:0];
         tvcc_pkg::RegExponent: cfg.cost_exponent = val[3:0];
         tvcc_pkg::RegRadius:   cfg.turn_radius_min = val[14:0];
         default:               cfg.time_step = val[15:0];
      endcase
   endfunction

   function longint unsigned root32(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 30;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Note one accepted sample; queue a cost when it closes an enabled trajectory.
   function void note_sample(tvcc_pkg::req_type s);
      longint vx, vy, wz, vel, ratio, d;
      longint unsigned ext, viol, add, base, r;
      logic [31:0] sq;
      logic sat;
      tvcc_pkg::rsp_type res;
      vx = s.lin_x;
      vy = s.lin_y;
      wz = s.yaw_rate;
      if (!cfg.enable) begin
         if (s.row_end) viol_sum = '0;
         return;
      end
      vel = vx;
      ext = 0;
      if (cfg.motion_mode == tvcc_pkg::ModeOmni) begin
         sq = 32'(vx * vx) + 32'(vy * vy);
         vel = longint'(root32(longint'(sq)));
         if (vx <= 0) vel = -vel;
      end else if (cfg.motion_mode == tvcc_pkg::ModeAck && wz != 0) begin
         ratio = ((vx < 0 ? -vx : vx) << 12) / (wz < 0 ? -wz : wz);
         if (longint'(cfg.turn_radius_min) > ratio) ext = cfg.turn_radius_min - ratio;
      end
      viol = ext;
      if (vel > longint'(cfg.speed_upper)) begin
         d = vel - longint'(cfg.speed_upper);
         viol += d;
      end
      if (longint'(cfg.speed_lower) > vel) begin
         d = longint'(cfg.speed_lower) - vel;
         viol += d;
      end
      add = viol * cfg.time_step;
      if (add > 64'(tvcc_pkg::SumMax) - viol_sum) viol_sum = tvcc_pkg::SumMax;
      else viol_sum = 48'(viol_sum + add);
      if (!s.row_end) return;
      sat = 1'b0;
      base = (64'(viol_sum) * cfg.cost_gain) >> 20;
      if (base > 64'hFFFF_FFFF) begin
         base = 64'hFFFF_FFFF;
         sat = 1'b1;
      end
      r = base;
      for (int i = 1; i < cfg.cost_exponent; i++) begin
         r = (r * base) >> 16;
         if (r > 64'hFFFF_FFFF) begin
            r = 64'hFFFF_FFFF;
            sat = 1'b1;
         end
      end
      res.traj_cost = r[31:0];
      res.saturated = sat;
      pending.push_back(res);
      viol_sum = '0;
   endfunction

   function void check_cost(tvcc_pkg::rsp_type got);
      tvcc_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $error("unexpected cost %h", got.traj_cost);
         errors++;
         return;
      end
      want = pending.pop_front();
      checked++;
      if (got.traj_cost !== want.traj_cost) begin
         $error("traj_cost: expected %h actual %h", want.traj_cost, got.traj_cost);
         errors++;
      end
      if (got.saturated !== want.saturated) begin
         $error("saturated: expected %b actual %b", want.saturated, got.saturated);
         errors++;
      end
   endfunction
endclass

module tb_trajectory_velocity_constraint_cost;
   import tvcc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   cost_scoreboard board = new();
   int cycles = 0;
   int samples = 0;
   int phases = 0;
   bit rsp_hold_on = 1'b1;

   // Worst sample: an ackermann sample that closes a trajectory at the top power.
   localparam int CycleLimit = 2_000_000;

   trajectory_velocity_constraint_cost dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run; a hang means a lost handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Check every cost that the receiver takes.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_cost(rsp_data);
   end

   // Stall the result side: often not at all, often briefly, sometimes long.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (rsp_hold_on) begin
            g = gap_len();
            if (g != 0) begin
               rsp_ready <= 1'b0;
               repeat (g) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
      end
   end

   // Write one register through the setup and access cycles.
   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CsrAddrWidth'({idx, 2'b00});
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.write_reg(idx, val);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Present one sample and hold it until it is accepted; start at a falling edge
   // and return at a falling edge once it is accepted, leaving valid for the following call or drain.
   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] w, logic last);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{lin_x: x, lin_y: y, yaw_rate: w, row_end: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(req_data);
      samples++;
      @(negedge clock);
   endtask

   // Drop valid, drain all expected costs, then let any sample in flight finish.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_config(bit extreme);
      logic [31:0] v;
      write_csr(RegEnable, 32'($urandom_range(0, 7) != 0));
      write_csr(RegMode, $urandom_range(0, 3));
      if (extreme) begin
         write_csr(RegUpper, $urandom_range(0, 1) ? 32'h7FFF : 32'h8000);
         write_csr(RegLower, $urandom_range(0, 1) ? 32'h8000 : 32'h7FFF);
         write_csr(RegGain, $urandom_range(0, 1) ? 32'hFFFF : 32'h0);
         write_csr(RegExponent, $urandom_range(0, 1) ? 32'hF : 32'h0);
         write_csr(RegRadius, $urandom_range(0, 1) ? 32'h7FFF : 32'h0);
         write_csr(RegStep, $urandom_range(0, 1) ? 32'hFFFF : 32'h0);
      end else begin
         v = $urandom_range(0, 8192);
         write_csr(RegUpper, v);
         write_csr(RegLower, -$urandom_range(0, 8192));
         write_csr(RegGain, $urandom_range(0, 2048));
         write_csr(RegExponent, $urandom_range(1, 4));
         write_csr(RegRadius, $urandom_range(0, 16384));
         write_csr(RegStep, $urandom);
      end
   endtask

   // Random trajectory of a few samples; mostly well formed, large values now and then.
   task automatic random_trajectory();
      int n;
      logic [15:0] x, y, w;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         x = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 16384)) - 8192);
         y = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 16384)) - 8192);
         w = ($urandom_range(0, 5) == 0) ? 16'h0 : 16'($urandom);
         send_sample(x, y, w, i == n - 1);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes in every mode, with reset settings first.
      for (int m = 0; m < 4; m++) begin
         if (m != 0) write_csr(RegMode, m);
         if (m == 2) write_csr(RegRadius, 32'h7FFF);
         send_sample(16'h7FFF, 16'h8000, 16'h0000, 1'b0);  // zero yaw rate
         send_sample(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
         send_sample(16'h0000, 16'hFFFF, 16'h0001, 1'b0);
         send_sample(16'hFFFF, 16'h0000, 16'h7FFF, 1'b1);
         drain();
      end
      // Overflow: huge step and gain, power eight, saturate the cost.
      write_csr(RegExponent, 32'h8);
      write_csr(RegStep, 32'hFFFF);
      write_csr(RegGain, 32'hFFFF);
      write_csr(RegMode, 32'h0);
      write_csr(RegUpper, 32'h8000);
      for (int i = 0; i < 4; i++) send_sample(16'h7FFF, 16'h0, 16'h0, i == 3);
      drain();
      write_csr(RegExponent, 32'h0);
      // Disabled: last sample still clears the sum.
      write_csr(RegEnable, 32'h0);
      send_sample(16'h7FFF, 16'h1, 16'h1, 1'b0);
      send_sample(16'h8000, 16'h1, 16'h1, 1'b1);
      drain();
      write_csr(RegEnable, 32'h1);
      send_sample(16'h0, 16'h0, 16'h0, 1'b1);
      drain();

      // Random phases with a fresh setting each, some at extremes.
      while (samples < 420) begin
         phases++;
         rsp_hold_on = (phases % 4 != 0);
         random_config(phases % 5 == 0);
         for (int t = 0; t < 12; t++) random_trajectory();
         drain();
      end
      // Leave the block at a well-formed setting and flush any partial sum.
      write_csr(RegEnable, 32'h1);
      send_sample(16'h0, 16'h0, 16'h0, 1'b1);
      drain();

      $display("covered %0d samples over %0d setting phases, %0d costs checked",
               samples, phases, board.checked);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
rtl/tvcc_pkg.sv
rtl/tvcc_ctrl.sv
rtl/tvcc_dp.sv
rtl/trajectory_velocity_constraint_cost.sv
rtl/tvcc_checker.sv
test/tb_trajectory_velocity_constraint_cost.sv
